### rtl/core/pfrf_pkg.sv
package pfrf_pkg;

    // Operation codes carried by a request and echoed with its result.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Work classes the front end hands to the back end.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Command fields are sized for the largest supported store
    // (256 columns by 32 pages); the back end narrows them to the build.
    localparam int CMD_COL_W  = 8;
    localparam int CMD_PAGE_W = 5;
    localparam int CMD_ADDR_W = 13;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0]            op;
        logic [1:0]            kind;
        logic                  color;
        logic [CMD_COL_W-1:0]  x_first;
        logic [CMD_COL_W-1:0]  x_last;
        logic [CMD_PAGE_W-1:0] page_first;
        logic [CMD_PAGE_W-1:0] page_last;
        logic [7:0]            mask_top;
        logic [7:0]            mask_bottom;
        logic [CMD_ADDR_W-1:0] addr;
    } pfrf_cmd_t;

endpackage

### rtl/core/pfrf_ram.sv
module pfrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/pfrf_front.sv
module pfrf_front
    import pfrf_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [6:0] s_x_left,
    input  logic [5:0] s_y_top,
    input  logic [7:0] s_x_right,
    input  logic [7:0] s_y_end,
    input  logic       s_color,
    input  logic [2:0] s_read_page,
    input  logic [6:0] s_read_column,
    input  logic       init_done,
    input  logic       q_ready,
    output logic       q_push,
    output pfrf_cmd_t  q_cmd
);

    localparam int ROWS = PAGES * 8;

    logic [7:0]            xr_sat;
    logic [8:0]            ye_sat;
    logic [8:0]            ye_last;
    logic [8:0]            page_first_w;
    logic [8:0]            page_last_w;
    logic                  fill_empty;
    logic                  read_ok;
    logic [CMD_ADDR_W-1:0] fill_base;
    logic [CMD_ADDR_W-1:0] read_addr;

    // Requests are taken only once the power-up clear has finished.
    assign s_ready = init_done && q_ready;
    assign q_push  = s_valid && s_ready;

    // Saturate the right edge and the row end, then check for an empty box.
    always_comb begin
        xr_sat = (s_x_right > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : s_x_right;
        ye_sat = ({1'b0, s_y_end} > 9'(ROWS)) ? 9'(ROWS) : {1'b0, s_y_end};
        ye_last = ye_sat - 9'd1;
        fill_empty = ({1'b0, s_x_left} > xr_sat) || ({3'b000, s_y_top} >= ye_sat);
        page_first_w = {6'b000000, s_y_top[5:3]};
        page_last_w = {3'b000, ye_last[8:3]};
        fill_base = CMD_ADDR_W'(s_y_top[5:3]) * CMD_ADDR_W'(COLUMNS);
    end

    // A read outside the store returns zero and touches nothing.
    always_comb begin
        read_ok = ({3'b000, s_read_page} < 6'(PAGES)) &&
                  ({2'b00, s_read_column} < 9'(COLUMNS));
        read_addr = CMD_ADDR_W'(s_read_page) * CMD_ADDR_W'(COLUMNS) +
                    CMD_ADDR_W'(s_read_column);
    end

    // Build the command for the back end.
    always_comb begin
        q_cmd.op          = s_operation;
        q_cmd.color       = s_color;
        q_cmd.x_first     = CMD_COL_W'(s_x_left);
        q_cmd.x_last      = xr_sat;
        q_cmd.page_first  = page_first_w[CMD_PAGE_W-1:0];
        q_cmd.page_last   = page_last_w[CMD_PAGE_W-1:0];
        q_cmd.mask_top    = FULL_BYTE << s_y_top[2:0];
        q_cmd.mask_bottom = FULL_BYTE >> (3'd7 - ye_last[2:0]);
        q_cmd.addr        = fill_base;
        case (s_operation)
            OP_CLEAR: begin
                q_cmd.kind = KIND_CLEAR;
            end
            OP_FILL: begin
                q_cmd.kind = fill_empty ? KIND_NONE : KIND_FILL;
            end
            OP_READ: begin
                q_cmd.kind = read_ok ? KIND_READ : KIND_NONE;
                q_cmd.addr = read_addr;
            end
            default: begin
                q_cmd.kind = KIND_NONE;
            end
        endcase
    end

endmodule

### rtl/core/pfrf_queue.sv
module pfrf_queue
    import pfrf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pfrf_cmd_t push_cmd,
    output logic      ready,
    input  logic      pop,
    output logic      valid,
    output pfrf_cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pfrf_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rptr_reg];

    // Pointer and fill-level update.
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/pfrf_back.sv
module pfrf_back
    import pfrf_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  pfrf_cmd_t  q_cmd,
    output logic       q_pop,
    output logic       init_done,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic [1:0] m_finished_operation
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    pfrf_cmd_t         cmd_reg, cmd_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic [7:0]        wb_mask_reg, wb_mask_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_read_byte_reg, m_read_byte_next;
    logic [1:0]        m_op_reg, m_op_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [ADDR_W-1:0] fill_addr;
    logic [7:0]        page_mask;
    logic [COL_W-1:0]  col_first;
    logic [COL_W-1:0]  col_last;
    logic [PAGE_W-1:0] page_first;
    logic [PAGE_W-1:0] page_last;

    pfrf_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign init_done            = (state_reg != ST_INIT);
    assign m_valid              = m_valid_reg;
    assign m_read_byte          = m_read_byte_reg;
    assign m_finished_operation = m_op_reg;

    // Narrow the command fields to this store's size.
    always_comb begin
        col_first  = cmd_reg.x_first[COL_W-1:0];
        col_last   = cmd_reg.x_last[COL_W-1:0];
        page_first = cmd_reg.page_first[PAGE_W-1:0];
        page_last  = cmd_reg.page_last[PAGE_W-1:0];
        fill_addr  = base_reg + ADDR_W'(col_reg);
        page_mask  = ((page_reg == page_first) ? cmd_reg.mask_top : FULL_BYTE) &
                     ((page_reg == page_last) ? cmd_reg.mask_bottom : FULL_BYTE);
    end

    // Sequencer: clear sweeps, fill read-modify-write walks and single reads.
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        page_next        = page_reg;
        col_next         = col_reg;
        base_next        = base_reg;
        sweep_next       = sweep_reg;
        wb_valid_next    = 1'b0;
        wb_addr_next     = wb_addr_reg;
        wb_mask_next     = wb_mask_reg;
        res_byte_next    = res_byte_reg;
        m_valid_next     = m_valid_reg;
        m_read_byte_next = m_read_byte_reg;
        m_op_next        = m_op_reg;
        q_pop            = 1'b0;
        ram_raddr        = fill_addr;
        ram_we           = wb_valid_reg;
        ram_waddr        = wb_addr_reg;
        ram_wdata        = cmd_reg.color ? (ram_rdata | wb_mask_reg)
                                         : (ram_rdata & ~wb_mask_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ADDR_LAST) begin
                    sweep_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    page_next     = q_cmd.page_first[PAGE_W-1:0];
                    col_next      = q_cmd.x_first[COL_W-1:0];
                    base_next     = q_cmd.addr[ADDR_W-1:0];
                    res_byte_next = '0;
                    ram_raddr     = q_cmd.addr[ADDR_W-1:0];
                    case (q_cmd.kind)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_FILL:  state_next = ST_FILL;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL: begin
                // Read one byte per cycle; it is written back in the following cycle.
                wb_valid_next = 1'b1;
                wb_addr_next  = fill_addr;
                wb_mask_next  = page_mask;
                if (col_reg == col_last) begin
                    col_next = col_first;
                    if (page_reg == page_last) begin
                        state_next = ST_DONE;
                    end else begin
                        page_next = page_reg + 1'b1;
                        base_next = base_reg + ADDR_W'(COLUMNS);
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_READ: begin
                res_byte_next = ram_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_read_byte_next = res_byte_reg;
                    m_op_next        = cmd_reg.op;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        page_reg        <= page_next;
        col_reg         <= col_next;
        base_reg        <= base_next;
        wb_addr_reg     <= wb_addr_next;
        wb_mask_reg     <= wb_mask_next;
        res_byte_reg    <= res_byte_next;
        m_read_byte_reg <= m_read_byte_next;
        m_op_reg        <= m_op_next;
    end

endmodule

### rtl/core/page_framebuffer_rect_fill.sv
// Monochrome page framebuffer of PAGES pages by COLUMNS columns with
// rectangle fill, whole-store clear and single-byte read.
// Requests arrive on the s_ channel (valid/ready) and each produces exactly
// one result on the m_ channel: m_read_byte holds the stored byte for a read
// and zero otherwise, m_finished_operation echoes the operation code.
// A front end classifies each request and pushes it into a two-entry command
// queue; a back end sequencer works on one command at a time against a
// single-port-write, registered-read byte store.
// Work per request once it leaves the queue:
//   clear: every byte of the store (one byte written per cycle),
//   fill:  every byte of the touched pages and columns (one byte read-modify-write
//          per cycle through the store's registered read port),
//   read:  one store read; empty fills, reads outside the store and unused codes go straight to the result.
// After reset the store is cleared by a pass over all PAGES*COLUMNS bytes
// (1024 with the default size), during which s_ready stays low.
// When the receiver stalls, the result is held in the output register, the
// sequencer waits with its next result, and the queue keeps taking requests
// until it is full, after which s_ready drops.
module page_framebuffer_rect_fill
    import pfrf_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [6:0] s_x_left,
    input  logic [5:0] s_y_top,
    input  logic [7:0] s_x_right,
    input  logic [7:0] s_y_end,
    input  logic       s_color,
    input  logic [2:0] s_read_page,
    input  logic [6:0] s_read_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic [1:0] m_finished_operation
);

    logic      init_done;
    logic      q_ready;
    logic      q_push;
    pfrf_cmd_t q_push_cmd;
    logic      q_valid;
    logic      q_pop;
    pfrf_cmd_t q_pop_cmd;

    pfrf_front #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_x_left     (s_x_left),
        .s_y_top      (s_y_top),
        .s_x_right    (s_x_right),
        .s_y_end      (s_y_end),
        .s_color      (s_color),
        .s_read_page  (s_read_page),
        .s_read_column(s_read_column),
        .init_done    (init_done),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    pfrf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(q_push_cmd),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_cmd (q_pop_cmd)
    );

    pfrf_back #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_cmd               (q_pop_cmd),
        .q_pop               (q_pop),
        .init_done           (init_done),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_byte         (m_read_byte),
        .m_finished_operation(m_finished_operation)
    );

endmodule

### dv/page_framebuffer_rect_fill_checker.sv
module page_framebuffer_rect_fill_checker
    import pfrf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [6:0] s_x_left,
    input  logic [5:0] s_y_top,
    input  logic [7:0] s_x_right,
    input  logic [7:0] s_y_end,
    input  logic       s_color,
    input  logic [2:0] s_read_page,
    input  logic [6:0] s_read_column,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_read_byte,
    input  logic [1:0] m_finished_operation,
    output int         mismatch_count,
    output int         results_pending,
    output int         results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int ROWS        = PAGES * 8;
    localparam int STORE_BYTES = PAGES * COLUMNS;

    typedef struct {
        logic [7:0] read_byte;
        logic [1:0] operation;
    } frame_result_t;

    // Shadow copy of the frame and the results still owed by the block.
    logic [7:0]    frame_image [STORE_BYTES];
    frame_result_t owed_results [$];

    // Sets or clears the pixels of one rectangle in the shadow frame.
    function automatic void paint_rectangle(input logic [6:0] x_left, input logic [5:0] y_top,
                                            input logic [7:0] x_right, input logic [7:0] y_end,
                                            input logic white);
        int         first_col;
        int         last_col;
        int         top_row;
        int         row_end;
        int         page;
        int         col;
        int         lo;
        int         hi;
        logic [7:0] mask;
        first_col = int'(x_left);
        top_row   = int'(y_top);
        last_col  = (int'(x_right) > COLUMNS - 1) ? COLUMNS - 1 : int'(x_right);
        row_end   = (int'(y_end) > ROWS) ? ROWS : int'(y_end);
        // An empty or inverted rectangle leaves the frame alone.
        if (first_col > last_col || top_row >= row_end) begin
            return;
        end
        for (page = top_row / 8; page <= (row_end - 1) / 8; page++) begin
            lo   = (top_row > page * 8) ? top_row - page * 8 : 0;
            hi   = (row_end < page * 8 + 8) ? row_end - page * 8 : 8;
            mask = (FULL_BYTE << lo) & (FULL_BYTE >> (8 - hi));
            for (col = first_col; col <= last_col; col++) begin
                if (white) begin
                    frame_image[page * COLUMNS + col] |= mask;
                end else begin
                    frame_image[page * COLUMNS + col] &= ~mask;
                end
            end
        end
    endfunction

    // Applies one request to the shadow frame and returns the result it owes.
    function automatic frame_result_t apply_request(input logic [1:0] operation,
                                                    input logic [6:0] x_left,
                                                    input logic [5:0] y_top,
                                                    input logic [7:0] x_right,
                                                    input logic [7:0] y_end,
                                                    input logic color,
                                                    input logic [2:0] read_page,
                                                    input logic [6:0] read_column);
        frame_result_t owed;
        owed.read_byte = '0;
        owed.operation = operation;
        case (operation)
            OP_CLEAR: begin
                foreach (frame_image[i]) frame_image[i] = '0;
            end
            OP_FILL: begin
                paint_rectangle(x_left, y_top, x_right, y_end, color);
            end
            OP_READ: begin
                if (int'(read_page) < PAGES && int'(read_column) < COLUMNS) begin
                    owed.read_byte = frame_image[int'(read_page) * COLUMNS + int'(read_column)];
                end
            end
            default: begin
            end
        endcase
        return owed;
    endfunction

    task automatic report_mismatch(input string detail);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: result mismatch: %s", $time, detail);
        end
    endtask

    // Predict on every accepted request, compare on every accepted result.
    always @(posedge aclk) begin
        frame_result_t oldest;
        if (!aresetn) begin
            foreach (frame_image[i]) frame_image[i] = '0;
            owed_results.delete();
            mismatch_count  = 0;
            results_checked = 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_results.push_back(apply_request(s_operation, s_x_left, s_y_top, s_x_right,
                                                     s_y_end, s_color, s_read_page,
                                                     s_read_column));
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte=%02h op=%0d",
                                              m_read_byte, m_finished_operation));
                end else begin
                    oldest = owed_results.pop_front();
                    if (m_read_byte !== oldest.read_byte ||
                        m_finished_operation !== oldest.operation) begin
                        report_mismatch($sformatf(
                            "expected byte=%02h op=%0d, got byte=%02h op=%0d",
                            oldest.read_byte, oldest.operation, m_read_byte,
                            m_finished_operation));
                    end
                end
            end
        end
        results_pending = owed_results.size();
    end

endmodule

### dv/page_framebuffer_rect_fill_test.sv
module page_framebuffer_rect_fill_test
    import pfrf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         RANDOM_REQUESTS = 555;
    localparam int         QUIET_TAIL      = 80;
    localparam int         HOLDOFF_AFTER   = 200;
    localparam int         HOLDOFF_CYCLES  = 400;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_operation;
    logic [6:0] s_x_left;
    logic [5:0] s_y_top;
    logic [7:0] s_x_right;
    logic [7:0] s_y_end;
    logic       s_color;
    logic [2:0] s_read_page;
    logic [6:0] s_read_column;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_read_byte;
    logic [1:0] m_finished_operation;

    int mismatch_count;
    int results_pending;
    int results_checked;

    int requests_sent      = 0;
    int op_count [4]       = '{0, 0, 0, 0};
    int input_stall_cycles = 0;
    bit idle_on            = 1'b1;

    page_framebuffer_rect_fill uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_x_left             (s_x_left),
        .s_y_top              (s_y_top),
        .s_x_right            (s_x_right),
        .s_y_end              (s_y_end),
        .s_color              (s_color),
        .s_read_page          (s_read_page),
        .s_read_column        (s_read_column),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_read_byte          (m_read_byte),
        .m_finished_operation (m_finished_operation)
    );

    page_framebuffer_rect_fill_checker frame_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_x_left             (s_x_left),
        .s_y_top              (s_y_top),
        .s_x_right            (s_x_right),
        .s_y_end              (s_y_end),
        .s_color              (s_color),
        .s_read_page          (s_read_page),
        .s_read_column        (s_read_column),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_read_byte          (m_read_byte),
        .m_finished_operation (m_finished_operation),
        .mismatch_count       (mismatch_count),
        .results_pending      (results_pending),
        .results_checked      (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Idling happens in stretches, with every fourth stretch left quiet.
    function automatic bit idling_now();
        return idle_on && ((requests_sent / 40) % 4 != 3);
    endfunction

    // Offers one request and waits until the block takes it.
    task automatic send_request(input logic [1:0] operation, input logic [6:0] x_left,
                                input logic [5:0] y_top, input logic [7:0] x_right,
                                input logic [7:0] y_end, input logic color,
                                input logic [2:0] read_page, input logic [6:0] read_column);
        if (idling_now() && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= operation;
        s_x_left      <= x_left;
        s_y_top       <= y_top;
        s_x_right     <= x_right;
        s_y_end       <= y_end;
        s_color       <= color;
        s_read_page   <= read_page;
        s_read_column <= read_column;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        op_count[operation]++;
    endtask

    task automatic fill_request(input logic [6:0] x_left, input logic [5:0] y_top,
                                input logic [7:0] x_right, input logic [7:0] y_end,
                                input logic color);
        send_request(OP_FILL, x_left, y_top, x_right, y_end, color, 3'($urandom),
                     7'($urandom));
    endtask

    task automatic read_request(input logic [2:0] read_page, input logic [6:0] read_column);
        send_request(OP_READ, 7'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom), read_page, read_column);
    endtask

    // Counts cycles in which a stalled receiver backs up into the input.
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready && !m_ready) begin
            input_stall_cycles++;
        end
    end

    // Receiver: random stalls, one long hold-off, and none near the end.
    initial begin
        bit holdoff_done;
        holdoff_done = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!holdoff_done && requests_sent >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else if (idling_now() && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Reset, directed requests, random requests and the verdict.
    initial begin
        int         pick;
        logic [6:0] x_left;
        logic [5:0] y_top;
        logic [7:0] x_right;
        logic [7:0] y_end;
        logic [6:0] last_x_left;
        logic [5:0] last_y_top;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_CLEAR;
        s_x_left      <= '0;
        s_y_top       <= '0;
        s_x_right     <= '0;
        s_y_end       <= '0;
        s_color       <= 1'b0;
        s_read_page   <= '0;
        s_read_column <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // The store starts cleared.
        read_request(3'd0, 7'd0);
        // Whole screen white, with both far edges saturating.
        fill_request(7'd0, 6'd0, 8'd255, 8'd255, 1'b1);
        read_request(3'd7, 7'd127);
        read_request(3'd0, 7'd0);
        // Black strip crossing a page boundary: partial masks on both pages.
        fill_request(7'd5, 6'd3, 8'd5, 8'd13, 1'b0);
        read_request(3'd0, 7'd5);
        read_request(3'd1, 7'd5);
        // A single row inside one page.
        fill_request(7'd127, 6'd10, 8'd127, 8'd11, 1'b0);
        read_request(3'd1, 7'd127);
        // Empty and inverted rectangles change nothing.
        fill_request(7'd10, 6'd0, 8'd9, 8'd64, 1'b0);
        fill_request(7'd0, 6'd20, 8'd127, 8'd20, 1'b0);
        fill_request(7'd0, 6'd40, 8'd127, 8'd5, 1'b0);
        fill_request(7'd0, 6'd0, 8'd0, 8'd0, 1'b0);
        read_request(3'd1, 7'd10);
        read_request(3'd5, 7'd64);
        // Bottom-right pixel, with the right edge and row end just past the frame.
        fill_request(7'd127, 6'd63, 8'd128, 8'd65, 1'b0);
        read_request(3'd7, 7'd127);
        // The unused code with every field at its top.
        send_request(OP_UNUSED, 7'd127, 6'd63, 8'd255, 8'd255, 1'b1, 3'd7, 7'd127);
        read_request(3'd3, 7'd3);
        send_request(OP_CLEAR, 7'd127, 6'd63, 8'd255, 8'd255, 1'b1, 3'd7, 7'd127);
        read_request(3'd7, 7'd127);
        // One full column, then the last row across the whole width.
        fill_request(7'd0, 6'd0, 8'd0, 8'd64, 1'b1);
        read_request(3'd4, 7'd0);
        fill_request(7'd0, 6'd63, 8'd127, 8'd64, 1'b1);
        read_request(3'd7, 7'd64);

        // Random part: mostly small fills and reads around the latest fill.
        last_x_left = '0;
        last_y_top  = '0;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            idle_on = (i < RANDOM_REQUESTS - QUIET_TAIL);
            pick    = $urandom_range(0, 99);
            if (pick < 3) begin
                send_request(OP_CLEAR, 7'($urandom), 6'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom), 3'($urandom), 7'($urandom));
            end else if (pick < 6) begin
                send_request(OP_UNUSED, 7'($urandom), 6'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom), 3'($urandom), 7'($urandom));
            end else if (pick < 52) begin
                x_left = 7'($urandom_range(0, 127));
                y_top  = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 19) == 0) begin
                    x_right = 8'($urandom_range(0, 255));
                    y_end   = 8'($urandom_range(0, 255));
                end else begin
                    x_right = 8'(x_left) + 8'($urandom_range(0, 15));
                    y_end   = 8'(y_top) + 8'($urandom_range(0, 12));
                end
                last_x_left = x_left;
                last_y_top  = y_top;
                fill_request(x_left, y_top, x_right, y_end, 1'($urandom));
            end else if ($urandom_range(0, 1) == 0) begin
                read_request(last_y_top[5:3], last_x_left + 7'($urandom_range(0, 3)));
            end else begin
                read_request(3'($urandom), 7'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Drain every owed result, then give the block a little longer.
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests: %0d clears, %0d fills, %0d reads, %0d unused codes.",
                 requests_sent, op_count[OP_CLEAR], op_count[OP_FILL], op_count[OP_READ],
                 op_count[OP_UNUSED]);
        $display("Checked %0d results; input held back by the receiver for %0d cycles.",
                 results_checked, input_stall_cycles);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("page_framebuffer_rect_fill test passed");
        end else begin
            $display("page_framebuffer_rect_fill test failed");
        end
        $finish;
    end

    // Watchdog, well beyond a run in which every request is a full-screen walk.
    initial begin
        #12_000_000;
        $display("page_framebuffer_rect_fill test failed");
        $finish;
    end

endmodule
